FILE: rtl/multi_policy_task_scheduler_assert.svh
// Assertion macros for the scheduler checker.
`ifndef MULTI_POLICY_TASK_SCHEDULER_ASSERT_SVH
`define MULTI_POLICY_TASK_SCHEDULER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define MPTS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: scheduler assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define MPTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: scheduler assertion failed");

`endif

FILE: rtl/mpts_pkg.sv
// Types and constants shared by the task scheduler modules.
package mpts_pkg;

	// Operation codes of an input item.
	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_WAKE = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	// Policy codes.
	localparam logic [2:0] POL_FIFO  = 3'd0;
	localparam logic [2:0] POL_SJF   = 3'd1;
	localparam logic [2:0] POL_SRTF  = 3'd2;
	localparam logic [2:0] POL_RR    = 3'd3;
	localparam logic [2:0] POL_PRIO  = 3'd4;
	localparam logic [2:0] POL_AGING = 3'd5;

	typedef struct packed {
		logic [1:0]  operation;
		logic [3:0]  task_id;
		logic [15:0] run_length;
		logic [7:0]  base_prio;
		logic        running_blocked;
	} task_item_t;

	typedef struct packed {
		logic       chosen_valid;
		logic [3:0] chosen_id;
		logic       rejected;
	} result_item_t;

	// Source of the task table read address.
	typedef enum logic [1:0] {
		RD_RUN   = 2'd0,
		RD_QUEUE = 2'd1,
		RD_WIN   = 2'd2
	} rd_sel_t;

	// Kind of task table write.
	typedef enum logic [2:0] {
		WR_NONE   = 3'd0,
		WR_NEW    = 3'd1,
		WR_TL_DEC = 3'd2,
		WR_BASE   = 3'd3,
		WR_AGE    = 3'd4
	} wr_op_t;

	// Update of the pending result.
	typedef enum logic [2:0] {
		RES_HOLD = 3'd0,
		RES_ZERO = 3'd1,
		RES_REJ  = 3'd2,
		RES_RUN  = 3'd3,
		RES_WIN  = 3'd4
	} res_sel_t;

	typedef struct packed {
		logic     ld_in;
		logic     rd_en;
		rd_sel_t  rd_sel;
		wr_op_t   wr_op;
		logic     push_tail_in;
		logic     requeue_run;
		logic     take;
		logic     scan;
		logic     idx_clr;
		logic     idx_inc;
		logic     run_clr;
		logic     run_set;
		res_sel_t res_sel;
		logic     out_load;
	} mpts_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       id_ok;
		logic       full;
		logic       empty;
		logic       cont;
		logic       keep;
		logic       aging;
		logic       idx_last;
		logic       out_free;
	} mpts_sts_t;

endpackage

FILE: rtl/mpts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mpts_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/mpts_datapath.sv
// Datapath: ready queue, task table, running task, best-pick search and result registers.
module mpts_datapath import mpts_pkg::*; #(
	parameter int TASK_SLOTS = 16,
	parameter int TIME_BITS  = 16,
	parameter int PRIO_BITS  = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  mpts_cmd_t    cmd,
	output mpts_sts_t    sts,
	input  task_item_t   task_item,
	input  logic         policy_we,
	input  logic [2:0]   policy_data,
	output logic         result_valid,
	input  logic         result_stall,
	output result_item_t result_item
);

	localparam int SW = $clog2(TASK_SLOTS);
	localparam int CW = $clog2(TASK_SLOTS + 1);
	localparam int EW = 2 * TIME_BITS + 2 * PRIO_BITS;

	task_item_t            in_q;
	logic [2:0]            policy_q;
	logic [SW-1:0]         q_q [TASK_SLOTS];
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         idx_q;
	logic [SW-1:0]         run_id_q;
	logic                  run_v_q;
	logic [SW-1:0]         win_q;
	logic [SW-1:0]         rd_addr_q;
	logic                  cmp_v_s1;
	logic [SW-1:0]         pos_s1;
	logic [SW-1:0]         best_pos_q;
	logic [TIME_BITS-1:0]  best_tt_q;
	logic [TIME_BITS-1:0]  best_tl_q;
	logic [PRIO_BITS-1:0]  best_pn_q;
	result_item_t          res_q;
	result_item_t          out_q;
	logic                  out_v_q;

	logic [SW-1:0]         raddr;
	logic [SW-1:0]         waddr;
	logic [EW-1:0]         wdata;
	logic [EW-1:0]         rdata;
	logic                  we;
	logic [TIME_BITS-1:0]  r_tt;
	logic [TIME_BITS-1:0]  r_tl;
	logic [PRIO_BITS-1:0]  r_pn;
	logic [PRIO_BITS-1:0]  r_pb;
	logic [TIME_BITS-1:0]  len;
	logic [PRIO_BITS-1:0]  bp;
	logic [SW-1:0]         id_slot;
	logic [31:0]           id_w;
	logic [31:0]           len_w;
	logic [31:0]           bp_w;
	logic [31:0]           run_w;
	logic [31:0]           win_w;
	logic                  better;
	logic                  to_head;
	logic                  full;

	// Input fields widened and masked to the table widths.
	assign id_w    = 32'(in_q.task_id);
	assign len_w   = 32'(in_q.run_length);
	assign bp_w    = 32'(in_q.base_prio);
	assign id_slot = id_w[SW-1:0];
	assign len     = len_w[TIME_BITS-1:0];
	assign bp      = bp_w[PRIO_BITS-1:0];
	assign run_w   = 32'(run_id_q);
	assign win_w   = 32'(win_q);

	// Fields of the table entry just read.
	assign r_pb = rdata[PRIO_BITS-1:0];
	assign r_pn = rdata[2*PRIO_BITS-1:PRIO_BITS];
	assign r_tl = rdata[2*PRIO_BITS+TIME_BITS-1:2*PRIO_BITS];
	assign r_tt = rdata[EW-1:2*PRIO_BITS+TIME_BITS];

	assign full    = (count_q == CW'(TASK_SLOTS));
	assign to_head = (policy_q == POL_SRTF) || (policy_q == POL_PRIO);

	// Status toward the controller.
	always_comb begin
		sts.op       = in_q.operation;
		sts.id_ok    = (id_w < 32'(TASK_SLOTS));
		sts.full     = full;
		sts.empty    = (count_q == '0);
		sts.cont     = run_v_q && !in_q.running_blocked && (r_tl != '0);
		sts.keep     = (policy_q == POL_FIFO) || (policy_q == POL_SJF) ||
		               (policy_q > POL_AGING) || full;
		sts.aging    = (policy_q == POL_AGING);
		sts.idx_last = (idx_q == count_q - CW'(1));
		sts.out_free = !out_v_q || !result_stall;
	end

	// Table read address selection.
	always_comb begin
		case (cmd.rd_sel)
			RD_RUN:   raddr = run_id_q;
			RD_QUEUE: raddr = q_q[idx_q[SW-1:0]];
			RD_WIN:   raddr = win_q;
			default:  raddr = run_id_q;
		endcase
	end

	// Table write data: new entry or read-modify-write of the last entry read.
	always_comb begin
		we    = 1'b1;
		waddr = rd_addr_q;
		wdata = rdata;
		case (cmd.wr_op)
			WR_NEW: begin
				waddr = id_slot;
				wdata = {len, len, bp, bp};
			end
			WR_TL_DEC: begin
				wdata = {r_tt, (r_tl == '0) ? r_tl : r_tl - TIME_BITS'(1), r_pn, r_pb};
			end
			WR_BASE: begin
				wdata = {r_tt, r_tl, r_pb, r_pb};
			end
			WR_AGE: begin
				wdata = {r_tt, r_tl, (&r_pn) ? r_pn : r_pn + PRIO_BITS'(1), r_pb};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	mpts_ram #(
		.WIDTH(EW),
		.DEPTH(TASK_SLOTS)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Compare the entry read during a scan with the best so far.
	always_comb begin
		case (policy_q)
			POL_SJF:   better = r_tt < best_tt_q;
			POL_SRTF:  better = r_tl < best_tl_q;
			POL_PRIO:  better = r_pn > best_pn_q;
			POL_AGING: better = r_pn > best_pn_q;
			default:   better = 1'b0;
		endcase
	end

	// Payload registers: input item, read address, scan pipeline and best pick.
	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			in_q <= task_item;
		end
		if (cmd.rd_en) begin
			rd_addr_q <= raddr;
		end
		pos_s1 <= idx_q[SW-1:0];
		if (cmp_v_s1 && ((pos_s1 == '0) || better)) begin
			best_pos_q <= pos_s1;
			best_tt_q  <= r_tt;
			best_tl_q  <= r_tl;
			best_pn_q  <= r_pn;
		end
		if (cmd.take) begin
			win_q <= q_q[best_pos_q];
		end
	end

	// Ready queue storage: tail push, head push and removal at a position.
	always_ff @(posedge clk) begin
		if (cmd.push_tail_in) begin
			q_q[count_q[SW-1:0]] <= id_slot;
		end else if (cmd.requeue_run) begin
			if (to_head) begin
				for (int i = TASK_SLOTS - 1; i > 0; i--) begin
					q_q[i] <= q_q[i-1];
				end
				q_q[0] <= run_id_q;
			end else begin
				q_q[count_q[SW-1:0]] <= run_id_q;
			end
		end else if (cmd.take) begin
			for (int i = 0; i < TASK_SLOTS - 1; i++) begin
				if (SW'(i) >= best_pos_q) begin
					q_q[i] <= q_q[i+1];
				end
			end
		end
	end

	// Control registers: policy, queue count, index, running task, scan flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FIFO;
			count_q  <= '0;
			idx_q    <= '0;
			run_id_q <= '0;
			run_v_q  <= 1'b0;
			cmp_v_s1 <= 1'b0;
		end else begin
			if (policy_we) begin
				policy_q <= policy_data;
			end
			if (cmd.push_tail_in || cmd.requeue_run) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.take) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.run_set) begin
				run_id_q <= win_q;
				run_v_q  <= 1'b1;
			end else if (cmd.run_clr) begin
				run_v_q <= 1'b0;
			end
			cmp_v_s1 <= cmd.scan;
		end
	end

	// Pending result of the item at work.
	always_ff @(posedge clk) begin
		case (cmd.res_sel)
			RES_ZERO: res_q <= '0;
			RES_REJ:  res_q <= '{chosen_valid: 1'b0, chosen_id: 4'd0, rejected: 1'b1};
			RES_RUN:  res_q <= '{chosen_valid: 1'b1, chosen_id: run_w[3:0], rejected: 1'b0};
			RES_WIN:  res_q <= '{chosen_valid: 1'b1, chosen_id: win_w[3:0], rejected: 1'b0};
			default:  res_q <= res_q;
		endcase
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_v_q <= 1'b1;
		end else if (!result_stall) begin
			out_v_q <= 1'b0;
		end
	end

	assign result_valid = out_v_q;
	assign result_item  = out_q;

endmodule

FILE: rtl/mpts_ctrl.sv
// Controller: state machine that sequences each item through the datapath.
module mpts_ctrl import mpts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      task_valid,
	output logic      task_stall,
	input  mpts_sts_t sts,
	output mpts_cmd_t cmd
);

	typedef enum logic [17:0] {
		S_IDLE   = 18'h00001,
		S_DEC    = 18'h00002,
		S_RUNW   = 18'h00004,
		S_RUN    = 18'h00008,
		S_CHK    = 18'h00010,
		S_SCAN   = 18'h00020,
		S_SDRAIN = 18'h00040,
		S_TAKE   = 18'h00080,
		S_ABRD   = 18'h00100,
		S_ABW    = 18'h00200,
		S_ABWR   = 18'h00400,
		S_AIRD   = 18'h00800,
		S_AIW    = 18'h01000,
		S_AIWR   = 18'h02000,
		S_CRD    = 18'h04000,
		S_CW     = 18'h08000,
		S_CWR    = 18'h10000,
		S_FIN    = 18'h20000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign task_stall = (state_q != S_IDLE);

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (task_valid) begin
					cmd.ld_in = 1'b1;
					state_d   = S_DEC;
				end
			end
			S_DEC: begin
				state_d = S_FIN;
				if (sts.op == OP_ADD || sts.op == OP_WAKE) begin
					if (!sts.id_ok) begin
						cmd.res_sel = RES_ZERO;
					end else if (sts.full) begin
						cmd.res_sel = RES_REJ;
					end else begin
						cmd.res_sel      = RES_ZERO;
						cmd.push_tail_in = 1'b1;
						if (sts.op == OP_ADD) begin
							cmd.wr_op = WR_NEW;
						end
					end
				end else if (sts.op == OP_TICK) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_RUN;
					state_d    = S_RUNW;
				end else begin
					cmd.res_sel = RES_ZERO;
				end
			end
			S_RUNW: begin
				state_d = S_RUN;
			end
			S_RUN: begin
				if (sts.cont && sts.keep) begin
					cmd.wr_op   = WR_TL_DEC;
					cmd.res_sel = RES_RUN;
					state_d     = S_FIN;
				end else begin
					cmd.requeue_run = sts.cont;
					cmd.run_clr     = 1'b1;
					state_d         = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.empty) begin
					cmd.res_sel = RES_ZERO;
					state_d     = S_FIN;
				end else begin
					cmd.idx_clr = 1'b1;
					state_d     = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = RD_QUEUE;
				cmd.scan    = 1'b1;
				cmd.idx_inc = 1'b1;
				if (sts.idx_last) begin
					state_d = S_SDRAIN;
				end
			end
			S_SDRAIN: begin
				state_d = S_TAKE;
			end
			S_TAKE: begin
				cmd.take = 1'b1;
				state_d  = sts.aging ? S_ABRD : S_CRD;
			end
			S_ABRD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_WIN;
				state_d    = S_ABW;
			end
			S_ABW: begin
				// Keep reading the winner so its entry is still on the read port.
				cmd.rd_sel = RD_WIN;
				state_d    = S_ABWR;
			end
			S_ABWR: begin
				cmd.wr_op   = WR_BASE;
				cmd.idx_clr = 1'b1;
				state_d     = sts.empty ? S_CRD : S_AIRD;
			end
			S_AIRD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_QUEUE;
				state_d    = S_AIW;
			end
			S_AIW: begin
				// Keep reading the same queued task for the write that follows.
				cmd.rd_sel = RD_QUEUE;
				state_d    = S_AIWR;
			end
			S_AIWR: begin
				cmd.wr_op = WR_AGE;
				if (sts.idx_last) begin
					state_d = S_CRD;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_AIRD;
				end
			end
			S_CRD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_WIN;
				state_d    = S_CW;
			end
			S_CW: begin
				cmd.rd_sel = RD_WIN;
				state_d    = S_CWR;
			end
			S_CWR: begin
				cmd.wr_op   = WR_TL_DEC;
				cmd.run_set = 1'b1;
				cmd.res_sel = RES_WIN;
				state_d     = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/multi_policy_task_scheduler.sv
// Multi-policy task scheduler: one item at a time. A tick that picks from the ready queue
// first scans the tasks queued when the scan starts, one task table read per cycle through
// the single-read-port table RAM; under priority with aging an aging pass follows, which
// does a read-modify-write of one queued task at a time.
module multi_policy_task_scheduler import mpts_pkg::*; #(
	parameter int TASK_SLOTS = 16,
	parameter int TIME_BITS  = 16,
	parameter int PRIO_BITS  = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         task_valid,
	output logic         task_stall,
	input  task_item_t   task_item,
	output logic         result_valid,
	input  logic         result_stall,
	output result_item_t result_item,
	input  logic         policy_we,
	input  logic [2:0]   policy_data
);

	mpts_cmd_t cmd;
	mpts_sts_t sts;

	// Sequencer.
	mpts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.task_valid(task_valid),
		.task_stall(task_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Queue, table and result path.
	mpts_datapath #(
		.TASK_SLOTS(TASK_SLOTS),
		.TIME_BITS (TIME_BITS),
		.PRIO_BITS (PRIO_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.task_item   (task_item),
		.policy_we   (policy_we),
		.policy_data (policy_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item (result_item)
	);

endmodule

FILE: rtl/mpts_checker.sv
// Port-level checker for the task scheduler and its bind.
`include "multi_policy_task_scheduler_assert.svh"

module mpts_checker import mpts_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         task_valid,
	input logic         task_stall,
	input logic         result_valid,
	input logic         result_stall,
	input result_item_t result_item
);

	// A stalled result holds.
	`MPTS_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
		result_valid && $stable(result_item))

	// Items are taken one at a time: the block is busy right after accepting one.
	`MPTS_ASSERT_NEXT(a_busy_after_accept, task_valid && !task_stall, task_stall)

	// A tick that picks a task never reports a rejection.
	`MPTS_ASSERT_NOW(a_chosen_not_rejected, result_valid && result_item.chosen_valid,
		!result_item.rejected)

	// With no task chosen the slot number reads zero.
	`MPTS_ASSERT_NOW(a_idle_id_zero, result_valid && !result_item.chosen_valid,
		result_item.chosen_id == 4'd0)

endmodule

bind multi_policy_task_scheduler mpts_checker u_mpts_checker (.*);
